[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the pair list parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define ASSERT_AFTER_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rpl_pkg.sv]
// Types and constants of the range pair list parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpl_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int COUNT_WIDTH = 16;
    localparam int CHAR_WIDTH  = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;

    localparam logic [CHAR_WIDTH-1:0] ELEMENT_SEP_RESET = 8'd45;
    localparam logic [CHAR_WIDTH-1:0] PAIR_SEP_RESET    = 8'd59;

    // Configuration register indexes
    localparam logic REG_ELEMENT_SEP = 1'b0;
    localparam logic REG_PAIR_SEP    = 1'b1;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] symbol;
        logic                  has_symbol;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] first_value;
        logic [VALUE_WIDTH-1:0] second_value;
        logic                   pair_ready;
        logic                   list_done;
        logic                   list_ok;
        logic [COUNT_WIDTH-1:0] pair_total;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/rpl_parser.sv]
// Parse state of the range pair list parser: phase, accumulators, error mark
// and pair count, with the per-character result. Depends on rpl_pkg.
`default_nettype none

module rpl_parser
    import rpl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire in_item_t              item,
    input  wire logic [CHAR_WIDTH-1:0] element_sep,
    input  wire logic [CHAR_WIDTH-1:0] pair_sep,
    output out_item_t                  res,
    output logic                       res_valid
);

    typedef enum logic [1:0] {
        PH_FIRST_START,
        PH_FIRST_DIGITS,
        PH_SECOND_START,
        PH_SECOND_DIGITS
    } phase_t;

    localparam int WIDE = VALUE_WIDTH + 4;

    phase_t                 phase_reg,  phase_next;
    logic [VALUE_WIDTH-1:0] first_reg,  first_next;
    logic [VALUE_WIDTH-1:0] second_reg, second_next;
    logic                   error_reg,  error_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;

    logic       is_digit;
    logic [3:0] digit;

    // acc * 10 + d, held at all ones once it would pass the value width
    function automatic logic [VALUE_WIDTH-1:0] accumulate(
        input logic [VALUE_WIDTH-1:0] acc,
        input logic [3:0]             d
    );
        logic [WIDE-1:0] wide_acc;
        logic [WIDE-1:0] sum;
        wide_acc = {4'b0, acc};
        sum = (wide_acc << 3) + (wide_acc << 1) + {{(WIDE-4){1'b0}}, d};
        if (sum[WIDE-1:VALUE_WIDTH] != '0) begin
            return '1;
        end
        return sum[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    assign is_digit = (item.symbol >= CHAR_ZERO) && (item.symbol <= CHAR_NINE);
    assign digit    = item.symbol[3:0] - CHAR_ZERO[3:0];

    always_comb begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        error_next  = error_reg;
        count_next  = count_reg;
        res         = '0;

        if (item.has_symbol && !error_reg) begin
            unique case (phase_reg) inside
                PH_FIRST_START, PH_FIRST_DIGITS: begin
                    if (is_digit) begin
                        first_next = accumulate(first_reg, digit);
                        phase_next = PH_FIRST_DIGITS;
                    end else if (phase_reg == PH_FIRST_DIGITS && item.symbol == element_sep) begin
                        phase_next = PH_SECOND_START;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                PH_SECOND_START, PH_SECOND_DIGITS: begin
                    if (is_digit) begin
                        second_next = accumulate(second_reg, digit);
                        phase_next  = PH_SECOND_DIGITS;
                    end else if (phase_reg == PH_SECOND_DIGITS && item.symbol == pair_sep) begin
                        res.pair_ready   = 1'b1;
                        res.first_value  = first_reg;
                        res.second_value = second_reg;
                        count_next       = bump(count_reg);
                        first_next       = '0;
                        second_next      = '0;
                        phase_next       = PH_FIRST_START;
                    end else begin
                        error_next = 1'b1;
                    end
                end
                default: begin
                    error_next = 1'b1;
                end
            endcase
        end

        if (item.last) begin
            res.list_done = 1'b1;
            if (!error_next) begin
                // a second number in progress closes the final pair
                if (phase_next == PH_SECOND_DIGITS) begin
                    res.pair_ready   = 1'b1;
                    res.first_value  = first_next;
                    res.second_value = second_next;
                    count_next       = bump(count_next);
                    res.list_ok      = 1'b1;
                end else if (phase_next == PH_FIRST_START && count_next != '0) begin
                    res.list_ok = 1'b1;
                end
            end
        end

        res.pair_total = count_next;

        // end of list: start the next one afresh
        if (item.last) begin
            phase_next  = PH_FIRST_START;
            first_next  = '0;
            second_next = '0;
            error_next  = 1'b0;
            count_next  = '0;
        end
    end

    assign res_valid = res.pair_ready || res.list_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST_START;
            first_reg  <= '0;
            second_reg <= '0;
            error_reg  <= 1'b0;
            count_reg  <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            error_reg  <= error_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/range_pair_list_parser_top.sv]
// Range pair list parser: top level with configuration registers and the
// two-entry result buffer. Depends on rpl_pkg and rpl_parser.
//
// Usage:
//   s_valid/s_ready/s_data carry one character of a pair list per transfer,
//   with has_symbol and last flags. m_valid/m_ready/m_data carry a result
//   when a pair completes or the list ends (at most one per character).
//   cfg_we/cfg_index/cfg_data write the element separator (index 0) and the
//   pair separator (index 1); write only while the block is idle.
// Result path: the result of a transferred character is registered in the main
//   register that drives m_data, or in the skid register while the output stalls.
// Throughput: one character per cycle while s_ready is high; the
//   multiply-by-ten accumulate and phase update are combinational.
// Stall: a result that arrives while the output is stalled goes to a skid
//   register, so characters are still taken; s_ready drops only while the skid
//   register is full, and rises again when the receiver takes a result.
// Reset: aresetn (synchronous, active low) empties the result buffer,
//   returns the parser to the start of a list and restores the separators
//   to '-' and ';'.
`default_nettype none

module range_pair_list_parser_top
    import rpl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,

    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CHAR_WIDTH-1:0] cfg_data
);

    logic [CHAR_WIDTH-1:0] element_sep_reg;
    logic [CHAR_WIDTH-1:0] pair_sep_reg;

    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      m_valid_reg, m_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    out_item_t res;
    logic      res_valid;
    logic      accept;
    logic      push;
    logic      pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign push    = accept && res_valid;
    assign pop     = m_valid_reg && m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = main_reg;

    rpl_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (s_data),
        .element_sep (element_sep_reg),
        .pair_sep    (pair_sep_reg),
        .res         (res),
        .res_valid   (res_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_sep_reg <= ELEMENT_SEP_RESET;
            pair_sep_reg    <= PAIR_SEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ELEMENT_SEP: element_sep_reg <= cfg_data;
                REG_PAIR_SEP:    pair_sep_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                // advance the skid entry; no transfer in while it was full
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                main_next = res;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg) begin
                main_next    = res;
                m_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

[hdl/rpl_checker.sv]
// Port-level checks on the range pair list parser result channel, bound to
// the top level. Depends on rpl_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rpl_checker
    import rpl_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    `ASSERT_AFTER_RESET(a_empty_after_reset, aclk, aresetn, !m_valid, "result valid after reset")

    `ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result dropped or changed")

    `ASSERT_IMPLIES(a_ok_needs_done, aclk, aresetn, m_valid && m_data.list_ok, m_data.list_done && (m_data.pair_total != '0), "list_ok without end of list or pairs")

    `ASSERT_IMPLIES(a_idle_values_zero, aclk, aresetn, m_valid && !m_data.pair_ready, (m_data.first_value == '0) && (m_data.second_value == '0), "values set without a pair")

    `ASSERT_IMPLIES(a_result_has_cause, aclk, aresetn, m_valid, m_data.pair_ready || m_data.list_done, "result with neither pair nor end")

endmodule

bind range_pair_list_parser_top rpl_checker u_rpl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/tb_range_pair_list_parser_top.sv]
// Self-checking testbench of the range pair list parser: directed lists, random lists under
// several separator settings and one long list sent without idling, with random handshake idling.
// Depends on rpl_pkg and range_pair_list_parser_top.
`timescale 1ns / 1ps

module tb_range_pair_list_parser_top;
    import rpl_pkg::*;

    localparam int CYCLE_LIMIT = 100_000;
    localparam int LONG_PAIRS  = 40;

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {WANT_FIRST, IN_FIRST, WANT_SECOND, IN_SECOND} phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = REG_ELEMENT_SEP;
    logic [CHAR_WIDTH-1:0] cfg_data  = '0;

    // Parser state as the block should hold it
    phase_t                 phase      = WANT_FIRST;
    logic [VALUE_WIDTH-1:0] acc_first  = '0;
    logic [VALUE_WIDTH-1:0] acc_second = '0;
    logic                   bad_syntax = 1'b0;
    logic [COUNT_WIDTH-1:0] pairs_seen = '0;
    logic [CHAR_WIDTH-1:0]  elem_sep   = ELEMENT_SEP_RESET;
    logic [CHAR_WIDTH-1:0]  pair_sep   = PAIR_SEP_RESET;

    out_item_t parsed_outputs[$];
    in_item_t  list_buf[$];
    int        live_items  = 0;
    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        calm        = 1'b0;

    range_pair_list_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [VALUE_WIDTH-1:0] shift_in_digit(input logic [VALUE_WIDTH-1:0] acc,
                                                              input logic [3:0] digit);
        longint unsigned wide;
        wide = 64'(acc);
        wide = wide * 64'd10 + 64'(digit);
        if (wide > VALUE_MAX)
            return VALUE_MAX;
        return wide[VALUE_WIDTH-1:0];
    endfunction

    function automatic void count_pair();
        if (pairs_seen != COUNT_MAX)
            pairs_seen++;
    endfunction

    // Advance the parser by one character; returns 1 when a result is due
    function automatic bit parse_symbol(input in_item_t it, output out_item_t res);
        bit is_digit;
        res = '0;
        if (it.has_symbol && !bad_syntax) begin
            is_digit = it.symbol >= CHAR_ZERO && it.symbol <= CHAR_NINE;
            case (phase) inside
                WANT_FIRST, IN_FIRST: begin
                    if (is_digit) begin
                        acc_first = shift_in_digit(acc_first, it.symbol[3:0]);
                        phase = IN_FIRST;
                    end else if (phase == IN_FIRST && it.symbol == elem_sep) begin
                        phase = WANT_SECOND;
                    end else begin
                        bad_syntax = 1'b1;
                    end
                end
                default: begin
                    if (is_digit) begin
                        acc_second = shift_in_digit(acc_second, it.symbol[3:0]);
                        phase = IN_SECOND;
                    end else if (phase == IN_SECOND && it.symbol == pair_sep) begin
                        res.pair_ready   = 1'b1;
                        res.first_value  = acc_first;
                        res.second_value = acc_second;
                        count_pair();
                        acc_first  = '0;
                        acc_second = '0;
                        phase = WANT_FIRST;
                    end else begin
                        bad_syntax = 1'b1;
                    end
                end
            endcase
        end
        if (it.last) begin
            res.list_done = 1'b1;
            if (!bad_syntax) begin
                // a second number still open is closed by the end of the list
                if (phase == IN_SECOND) begin
                    res.pair_ready   = 1'b1;
                    res.first_value  = acc_first;
                    res.second_value = acc_second;
                    count_pair();
                    res.list_ok = 1'b1;
                end else if (phase == WANT_FIRST && pairs_seen != 0) begin
                    res.list_ok = 1'b1;
                end
            end
        end
        res.pair_total = pairs_seen;
        if (it.last) begin
            phase      = WANT_FIRST;
            acc_first  = '0;
            acc_second = '0;
            bad_syntax = 1'b0;
            pairs_seen = '0;
        end
        return res.pair_ready || res.list_done;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (parsed_outputs.size() == 0) begin
            flag_mismatch($sformatf("result %h with nothing pending", got));
            return;
        end
        want = parsed_outputs.pop_front();
        if (got.first_value !== want.first_value)
            flag_mismatch($sformatf("first_value %0d, want %0d", got.first_value,
                                    want.first_value));
        if (got.second_value !== want.second_value)
            flag_mismatch($sformatf("second_value %0d, want %0d", got.second_value,
                                    want.second_value));
        if (got.pair_ready !== want.pair_ready)
            flag_mismatch($sformatf("pair_ready %b, want %b", got.pair_ready, want.pair_ready));
        if (got.list_done !== want.list_done)
            flag_mismatch($sformatf("list_done %b, want %b", got.list_done, want.list_done));
        if (got.list_ok !== want.list_ok)
            flag_mismatch($sformatf("list_ok %b, want %b", got.list_ok, want.list_ok));
        if (got.pair_total !== want.pair_total)
            flag_mismatch($sformatf("pair_total %0d, want %0d", got.pair_total,
                                    want.pair_total));
    endtask

    // Result side: check each transfer, and drop ready at random with a 22 percent chance unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            m_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    function automatic in_item_t char_item(input logic [CHAR_WIDTH-1:0] sym, input logic has,
                                           input logic fin);
        in_item_t it;
        it.symbol     = sym;
        it.has_symbol = has;
        it.last       = fin;
        return it;
    endfunction

    task automatic send_char(input in_item_t item);
        out_item_t res;
        if (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if ((item.has_symbol && !bad_syntax) || item.last)
            live_items++;
        if (parse_symbol(item, res))
            parsed_outputs.push_back(res);
    endtask

    // Drop valid and hold until every pending result has been taken
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (parsed_outputs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_separator(input logic idx, input logic [CHAR_WIDTH-1:0] val);
        wait_idle();
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_ELEMENT_SEP)
            elem_sep = val;
        else
            pair_sep = val;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(char_item(text[i], 1'b1, i == text.len() - 1));
    endtask

    // Occasionally slip in a bare marker that does nothing
    function automatic void put_char(input logic [CHAR_WIDTH-1:0] c);
        if ($urandom_range(99) < 3)
            list_buf.push_back(char_item(CHAR_WIDTH'($urandom_range(0, 255)), 1'b0, 1'b0));
        list_buf.push_back(char_item(c, 1'b1, 1'b0));
    endfunction

    function automatic void put_number();
        int r;
        int ndig;
        r = $urandom_range(99);
        ndig = (r < 80) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 9)
                                                           : $urandom_range(10, 12);
        repeat (ndig) put_char(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
    endfunction

    // Mostly well-formed lists, some broken, some pure noise
    task automatic send_list();
        int       kind;
        int       cut;
        in_item_t tail;
        list_buf.delete();
        kind = $urandom_range(99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 8))
                list_buf.push_back(char_item(CHAR_WIDTH'($urandom_range(0, 255)),
                                             $urandom_range(0, 9) != 0, 1'b0));
        end else begin
            for (int p = 0; p < $urandom_range(1, 5); p++) begin
                if (p != 0)
                    put_char(pair_sep);
                put_number();
                put_char(elem_sep);
                put_number();
            end
            if ($urandom_range(2) == 0)
                put_char(pair_sep);
            if (kind < 30) begin
                if ($urandom_range(1) == 1) begin
                    list_buf[$urandom_range(0, list_buf.size() - 1)] =
                        char_item(CHAR_WIDTH'($urandom_range(0, 255)), 1'b1, 1'b0);
                end else begin
                    cut = $urandom_range(0, list_buf.size() - 1);
                    while (list_buf.size() > cut) void'(list_buf.pop_back());
                end
            end
        end
        if (list_buf.size() == 0 || $urandom_range(3) == 0) begin
            list_buf.push_back(char_item(CHAR_WIDTH'($urandom_range(0, 255)), 1'b0, 1'b1));
        end else begin
            tail = list_buf.pop_back();
            tail.last = 1'b1;
            list_buf.push_back(tail);
        end
        foreach (list_buf[i])
            send_char(list_buf[i]);
    endtask

    task automatic test_directed();
        // empty list
        send_char(char_item(8'hFF, 1'b0, 1'b1));
        // first number one past the value range
        send_text("2147483648-9");
        // extreme bytes, error then end
        send_char(char_item(8'h00, 1'b1, 1'b0));
        send_char(char_item(8'hFF, 1'b1, 1'b1));
        // bare marker without end, then a list ending before its second number
        send_char(char_item(8'hA5, 1'b0, 1'b0));
        send_text("5-");
        // one pair given out, then the list ends inside the next
        send_text("7-3;8");
    endtask

    task automatic test_random_lists(input int budget);
        int start;
        start = live_items;
        while (live_items - start < budget) begin
            send_list();
            if ($urandom_range(99) < 8)
                wait_idle();
        end
    endtask

    task automatic test_separators();
        logic [CHAR_WIDTH-1:0] v;
        write_separator(REG_ELEMENT_SEP, 8'h00);
        write_separator(REG_PAIR_SEP, 8'hFF);
        test_random_lists(150);
        write_separator(REG_ELEMENT_SEP, 8'hFF);
        write_separator(REG_PAIR_SEP, 8'h00);
        test_random_lists(150);
        // a digit as separator: the digit wins inside a number
        write_separator(REG_ELEMENT_SEP, CHAR_ZERO + 8'd5);
        write_separator(REG_PAIR_SEP, CHAR_NINE);
        test_random_lists(100);
        v = CHAR_WIDTH'($urandom_range(0, 255));
        write_separator(REG_ELEMENT_SEP, v);
        write_separator(REG_PAIR_SEP, v);
        test_random_lists(100);
        write_separator(REG_ELEMENT_SEP, CHAR_WIDTH'($urandom_range(0, 255)));
        write_separator(REG_PAIR_SEP, CHAR_WIDTH'($urandom_range(0, 255)));
        test_random_lists(80);
        write_separator(REG_ELEMENT_SEP, ELEMENT_SEP_RESET);
        write_separator(REG_PAIR_SEP, PAIR_SEP_RESET);
    endtask

    // One long list of short pairs, sent and taken with no idling
    task automatic test_long_list();
        wait_idle();
        calm = 1'b1;
        for (int p = 0; p < LONG_PAIRS; p++) begin
            send_char(char_item(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)), 1'b1, 1'b0));
            send_char(char_item(elem_sep, 1'b1, 1'b0));
            send_char(char_item(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)), 1'b1, 1'b0));
            send_char(char_item(pair_sep, 1'b1, p == LONG_PAIRS - 1));
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_lists(400);
        test_separators();
        test_long_list();
        test_random_lists(50);
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
